[rtl/sorted_priority_job_queue_defines.svh]
// Assertion macros for the sorted priority job queue.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SORTED_PRIORITY_JOB_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_JOB_QUEUE_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define SPJQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define SPJQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/spjq_pkg.sv]
// Shared types and constants for the sorted priority job queue.
// No dependencies; used by spjq_cell and sorted_priority_job_queue.
package spjq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int JOB_ID_W       = 16;
    localparam int JOB_PRIORITY_W = 8;
    localparam int ENTRY_COUNT_W  = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]                mode;
        logic [JOB_ID_W-1:0]       job_id;
        logic [JOB_PRIORITY_W-1:0] job_priority;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                status;
        logic [JOB_ID_W-1:0]       out_job_id;
        logic [JOB_PRIORITY_W-1:0] out_priority;
        logic [ENTRY_COUNT_W-1:0]  entry_count;
    } t_out_item;

    // One job as it sits in a cell.
    typedef struct packed {
        logic [JOB_ID_W-1:0]       job_id;
        logic [JOB_PRIORITY_W-1:0] job_priority;
    } t_job;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                      ins;    // insert new_job in sorted order
        logic                      start;  // put the search token on the head cell
        logic                      adv;    // move the search token one cell on
        logic                      shl;    // close the gap at the token, tail moves up
        logic                      clr;    // drop the search token
        t_job                      new_job;
        logic [JOB_ID_W-1:0]       key;
    } t_cell_cmd;

endpackage

[rtl/spjq_cell.sv]
// One slot of the sorted job chain: holds a job, a search token and a passed flag.
// Depends on spjq_pkg.
module spjq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spjq_pkg::t_cell_cmd  i_cmd,
    input  logic                 i_head,
    input  logic                 i_occupied,
    input  spjq_pkg::t_job       i_right_job,
    input  spjq_pkg::t_job       i_left_job,
    input  logic                 i_left_lt,
    input  logic                 i_left_tok,
    output spjq_pkg::t_job       o_job,
    output logic                 o_lt,
    output logic                 o_tok,
    output logic                 o_seen,
    output logic                 o_hit
);

    spjq_pkg::t_job r_job;
    logic           r_tok;
    logic           r_seen;

    // Free slots and lower priorities sit at the tail, so this flag is a thermometer.
    assign o_lt  = !i_occupied || (r_job.job_priority < i_cmd.new_job.job_priority);
    assign o_hit = r_tok && i_occupied && (r_job.job_id == i_cmd.key);
    assign o_job  = r_job;
    assign o_tok  = r_tok;
    assign o_seen = r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_seen <= 1'b0;
        end else if (i_cmd.start) begin
            r_tok  <= i_head;
            r_seen <= 1'b0;
        end else if (i_cmd.adv) begin
            r_tok  <= i_left_tok;
            r_seen <= r_seen | r_tok;
        end else if (i_cmd.shl || i_cmd.clr) begin
            r_tok  <= 1'b0;
            r_seen <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (o_lt && i_left_lt) begin
                r_job <= i_left_job;
            end else if (o_lt) begin
                r_job <= i_cmd.new_job;
            end
        end else if (i_cmd.shl && !r_seen) begin
            r_job <= i_right_job;
        end
    end

endmodule

[rtl/sorted_priority_job_queue.sv]
// Sorted priority job queue built as a chain of cells, highest priority at the head and
// earlier arrivals ahead among equal priorities. Insert, pop and any unused mode are done
// in the idle state. Remove walks a search token down the chain one cell per cycle until
// it hits the job or passes the last job held, and remove on an empty queue reports empty
// without a search. The token walk sets the rate of remove; no new transaction is taken
// during it. Each result sits in an output register, so the next transaction is taken
// while the previous result is being handed over.
// Depends on spjq_pkg, spjq_cell and sorted_priority_job_queue_defines.svh.
`include "sorted_priority_job_queue_defines.svh"

module sorted_priority_job_queue #(
    parameter int QUEUE_DEPTH = spjq_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  spjq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spjq_pkg::t_out_item o_out_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    t_state                                r_state, n_state;
    logic [CW-1:0]                         r_count, n_count;
    logic [CW-1:0]                         r_pos, n_pos;
    logic [spjq_pkg::JOB_ID_W-1:0]         r_key, n_key;
    logic                                  r_out_valid, n_out_valid;
    spjq_pkg::t_out_item                   r_out_data, n_out_data;

    spjq_pkg::t_cell_cmd                   cmd;
    spjq_pkg::t_job                        cell_job [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]                cell_lt;
    logic [QUEUE_DEPTH-1:0]                cell_tok;
    logic [QUEUE_DEPTH-1:0]                cell_seen;
    logic [QUEUE_DEPTH-1:0]                cell_hit;
    logic [spjq_pkg::JOB_PRIORITY_W-1:0]   hit_priority;
    logic                                  any_hit;
    logic                                  in_fire;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Chain of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        spjq_pkg::t_job left_job;
        spjq_pkg::t_job right_job;
        logic           left_lt;
        logic           left_tok;

        if (g == 0) begin : g_head
            assign left_job = '0;
            assign left_lt  = 1'b0;
            assign left_tok = 1'b0;
        end else begin : g_body
            assign left_job = cell_job[g-1];
            assign left_lt  = cell_lt[g-1];
            assign left_tok = cell_tok[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_job = '0;
        end else begin : g_mid
            assign right_job = cell_job[g+1];
        end

        spjq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_head      (g == 0),
            .i_occupied  (CW'(g) < r_count),
            .i_right_job (right_job),
            .i_left_job  (left_job),
            .i_left_lt   (left_lt),
            .i_left_tok  (left_tok),
            .o_job       (cell_job[g]),
            .o_lt        (cell_lt[g]),
            .o_tok       (cell_tok[g]),
            .o_seen      (cell_seen[g]),
            .o_hit       (cell_hit[g])
        );
    end

    // At most one cell holds the token, so an AND-OR picks its priority.
    always_comb begin
        hit_priority = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            hit_priority = hit_priority |
                ({spjq_pkg::JOB_PRIORITY_W{cell_hit[i]}} & cell_job[i].job_priority);
        end
    end

    assign any_hit = |cell_hit;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_key       = r_key;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;

        cmd                      = '0;
        cmd.new_job.job_id       = i_in_data.job_id;
        cmd.new_job.job_priority = i_in_data.job_priority;
        cmd.key                  = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_out_data = '0;
                    case (i_in_data.mode)
                        spjq_pkg::MODE_INSERT: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_out_data.status = spjq_pkg::STATUS_FULL;
                            end else begin
                                cmd.ins           = 1'b1;
                                n_count           = r_count + 1'b1;
                                n_out_data.status = spjq_pkg::STATUS_OK;
                            end
                            n_out_valid = 1'b1;
                        end
                        spjq_pkg::MODE_POP: begin
                            if (r_count == '0) begin
                                n_out_data.status = spjq_pkg::STATUS_EMPTY;
                            end else begin
                                // Seen flags are clear when idle, so the whole chain moves up.
                                cmd.shl                 = 1'b1;
                                n_count                 = r_count - 1'b1;
                                n_out_data.status       = spjq_pkg::STATUS_OK;
                                n_out_data.out_job_id   = cell_job[0].job_id;
                                n_out_data.out_priority = cell_job[0].job_priority;
                            end
                            n_out_valid = 1'b1;
                        end
                        spjq_pkg::MODE_REMOVE: begin
                            if (r_count == '0) begin
                                n_out_data.status = spjq_pkg::STATUS_EMPTY;
                                n_out_valid       = 1'b1;
                            end else begin
                                cmd.start = 1'b1;
                                n_key     = i_in_data.job_id;
                                n_pos     = '0;
                                n_state   = S_SEARCH;
                            end
                        end
                        default: begin
                            n_out_data.status = spjq_pkg::STATUS_OK;
                            n_out_valid       = 1'b1;
                        end
                    endcase
                    n_out_data.entry_count = spjq_pkg::ENTRY_COUNT_W'(n_count);
                end
            end
            S_SEARCH: begin
                n_out_data = '0;
                if (any_hit) begin
                    cmd.shl                 = 1'b1;
                    n_count                 = r_count - 1'b1;
                    n_out_data.status       = spjq_pkg::STATUS_OK;
                    n_out_data.out_job_id   = r_key;
                    n_out_data.out_priority = hit_priority;
                    n_out_valid             = 1'b1;
                    n_state                 = S_IDLE;
                end else if (r_pos == r_count - 1'b1) begin
                    cmd.clr           = 1'b1;
                    n_out_data.status = spjq_pkg::STATUS_NOT_FOUND;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    cmd.adv = 1'b1;
                    n_pos   = r_pos + 1'b1;
                end
                n_out_data.entry_count = spjq_pkg::ENTRY_COUNT_W'(n_count);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_out_data <= n_out_data;
    end

    `SPJQ_ASSERT_ALWAYS(a_token_onehot0, $onehot0(cell_tok), "more than one search token")
    `SPJQ_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(QUEUE_DEPTH), "count above depth")
    `SPJQ_ASSERT_IMPLIES(a_idle_clean, r_state == S_IDLE, (cell_tok == '0) && (cell_seen == '0), "token or seen flag left while idle")
    `SPJQ_ASSERT_IMPLIES(a_search_out_free, r_state == S_SEARCH, !r_out_valid, "result pending during search")

endmodule
